[sv/lrc_pkg.sv]
`timescale 1ns / 1ps
package lrc_pkg;
    localparam int SET_COUNT_DEF    = 64;
    localparam int WAYS_DEF         = 4;
    localparam int LINE_BYTES_DEF   = 64;
    localparam int ADDR_BITS_DEF    = 32;
    localparam int MAX_PREFETCH_DEF = 8;

    localparam int PF_W    = 4;
    localparam int LAT_W   = 16;
    localparam int STAMP_W = 32;
    localparam logic [LAT_W-1:0] LAT_RESET = 16'd100;

    localparam logic REG_PREFETCH = 1'b0;
    localparam logic REG_LATENCY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_WRITE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture demand beat
        logic clr_wr;   // write one clearing row
        logic rd;       // issue set read
        logic look;     // register lookup result
        logic wr;       // write back set, advance line
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic last;     // current access is the final one of the item
    } t_sts;
endpackage

[sv/lrc_datapath.sv]
`timescale 1ns / 1ps
module lrc_datapath #(
    parameter int SET_COUNT    = lrc_pkg::SET_COUNT_DEF,
    parameter int WAYS         = lrc_pkg::WAYS_DEF,
    parameter int LINE_BYTES   = lrc_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS    = lrc_pkg::ADDR_BITS_DEF,
    parameter int MAX_PREFETCH = lrc_pkg::MAX_PREFETCH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lrc_pkg::t_cmd              i_cmd,
    output lrc_pkg::t_sts              o_sts,
    input  logic                       i_func,
    input  logic [ADDR_BITS-1:0]       i_address,
    input  logic [lrc_pkg::PF_W-1:0]   i_pf,
    output logic                       o_hit
);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SET_B = $clog2(SET_COUNT);
    localparam int TAG_W = ADDR_BITS - OFF_W - SET_B;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(MAX_PREFETCH + 1) + 1;
    localparam int SW    = lrc_pkg::STAMP_W;

    typedef struct packed {
        logic             v;
        logic             d;
        logic [TAG_W-1:0] tag;
        logic [SW-1:0]    stamp;
    } t_way;

    // one row per set, all ways side by side
    t_way [WAYS-1:0] r_mem [SET_COUNT];
    t_way [WAYS-1:0] r_row;
    t_way [WAYS-1:0] n_row;
    t_way [WAYS-1:0] r_new;

    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_wr;
    logic [CNT_W-1:0]     r_left;
    logic                 r_first;
    logic                 r_hit;
    logic [SW-1:0]        r_clock;
    logic [SET_W-1:0]     r_clr;
    logic                 r_clr_done;

    logic [SET_W-1:0]       w_set;
    logic [TAG_W-1:0]       w_tag;
    logic [ADDR_BITS-OFF_W-1:0] w_line;
    logic [SW-1:0]          w_stamp;
    logic                   w_hit;
    logic [CNT_W-1:0]       w_pf;

    assign w_line  = r_addr[ADDR_BITS-1:OFF_W];
    assign w_tag   = w_line[ADDR_BITS-OFF_W-1 -: TAG_W];
    assign w_stamp = r_clock + SW'(1);
    assign w_pf    = (CNT_W'(i_pf) > CNT_W'(MAX_PREFETCH)) ? CNT_W'(MAX_PREFETCH)
                                                            : CNT_W'(i_pf);

    generate
        if (SET_COUNT > 1) begin : g_set
            assign w_set = w_line[SET_W-1:0];
        end else begin : g_noset
            assign w_set = '0;
        end
    endgenerate

    // lookup: hit way, else last invalid, else oldest (first on tie)
    always_comb begin
        logic             found;
        logic             have_inv;
        logic             have_old;
        logic [WAY_W-1:0] inv_w;
        logic [WAY_W-1:0] old_w;
        logic [WAY_W-1:0] vic;
        found    = 1'b0;
        have_inv = 1'b0;
        have_old = 1'b0;
        inv_w    = '0;
        old_w    = '0;
        n_row    = r_row;
        for (int w = 0; w < WAYS; w++) begin
            if (!found) begin
                if (!r_row[w].v) begin
                    have_inv = 1'b1;
                    inv_w    = WAY_W'(w);
                end else if (r_row[w].tag == w_tag) begin
                    found = 1'b1;
                    n_row[w].stamp = w_stamp;
                    if (r_wr) n_row[w].d = 1'b1;
                end else if (!have_old || r_row[w].stamp < r_row[old_w].stamp) begin
                    have_old = 1'b1;
                    old_w    = WAY_W'(w);
                end
            end
        end
        vic = have_inv ? inv_w : old_w;
        if (!found) begin
            n_row[vic].v     = 1'b1;
            n_row[vic].d     = r_wr;
            n_row[vic].tag   = w_tag;
            n_row[vic].stamp = w_stamp;
        end
        w_hit = found;
    end

    // set memory: clearing sweep, read, lookup capture, write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[w_set] <= r_new;
        end
        if (i_cmd.rd) r_row <= r_mem[w_set];
        if (i_cmd.look) r_new <= n_row;
    end

    // hold access state, advance line per access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_hit      <= 1'b0;
            r_first    <= 1'b0;
            r_left     <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                if (r_clr == SET_W'(SET_COUNT - 1)) r_clr_done <= 1'b1;
                else r_clr <= r_clr + SET_W'(1);
            end
            if (i_cmd.load) begin
                r_addr  <= i_address;
                r_wr    <= i_func;
                r_left  <= w_pf;
                r_first <= 1'b1;
            end
            if (i_cmd.look) begin
                r_clock <= w_stamp;
                if (r_first) r_hit <= w_hit;
            end
            if (i_cmd.wr) begin
                r_first <= 1'b0;
                r_addr  <= r_addr + ADDR_BITS'(LINE_BYTES);
                if (r_left != '0) r_left <= r_left - CNT_W'(1);
            end
        end
    end

    assign o_sts.clr_done = r_clr_done;
    assign o_sts.last     = (r_left == '0);
    assign o_hit          = r_hit;
endmodule

[sv/lrc_ctrl.sv]
`timescale 1ns / 1ps
module lrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  lrc_pkg::t_sts i_sts,
    output lrc_pkg::t_cmd o_cmd
);
    lrc_pkg::t_state r_state;
    lrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lrc_pkg::ST_CLEAR;
        else r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrc_pkg::ST_CLEAR: if (i_sts.clr_done) n_state = lrc_pkg::ST_IDLE;
            lrc_pkg::ST_IDLE:  if (i_valid) n_state = lrc_pkg::ST_READ;
            lrc_pkg::ST_READ:  n_state = lrc_pkg::ST_LOOK;
            lrc_pkg::ST_LOOK:  n_state = lrc_pkg::ST_WRITE;
            lrc_pkg::ST_WRITE: n_state = i_sts.last ? lrc_pkg::ST_OUT : lrc_pkg::ST_READ;
            lrc_pkg::ST_OUT: begin
                if (i_ready) n_state = lrc_pkg::ST_IDLE;
            end
            default: n_state = lrc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            lrc_pkg::ST_CLEAR: o_cmd.clr_wr = !i_sts.clr_done;
            lrc_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            lrc_pkg::ST_READ:  o_cmd.rd = 1'b1;
            lrc_pkg::ST_LOOK:  o_cmd.look = 1'b1;
            lrc_pkg::ST_WRITE: o_cmd.wr = 1'b1;
            lrc_pkg::ST_OUT:   o_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

[sv/lru_set_assoc_cache_prefetch.sv]
`timescale 1ns / 1ps
// Tag model of a set-associative cache with LRU replacement and next-line
// prefetch. Demand beats arrive on i_valid/o_ready with i_func (0 read,
// 1 write) and i_address. Each demand is followed by up to prefetch_lines
// further accesses to the following lines, which update the tags silently.
// One result beat per demand leaves on o_valid/i_ready: o_hit and
// o_miss_cycles (miss_latency on a miss, zero on a hit).
// Each access runs read, lookup and write back in turn on the single set
// memory port, one access for the demand and one per clamped prefetch line;
// one item is in work at a time. Configuration: i_cfg_valid/o_cfg_ready
// with index 0 prefetch_lines, index 1 miss_latency; always ready. It must
// be written only while idle; the block itself does not enforce this.
// After reset the set memory is swept clear, one set a cycle, and no demand
// is accepted meanwhile. A stalled result holds its value and the block
// accepts no new demand until it is taken.
module lru_set_assoc_cache_prefetch #(
    parameter int SET_COUNT    = lrc_pkg::SET_COUNT_DEF,
    parameter int WAYS         = lrc_pkg::WAYS_DEF,
    parameter int LINE_BYTES   = lrc_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS    = lrc_pkg::ADDR_BITS_DEF,
    parameter int MAX_PREFETCH = lrc_pkg::MAX_PREFETCH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [ADDR_BITS-1:0]        i_address,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [lrc_pkg::LAT_W-1:0]   o_miss_cycles,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [lrc_pkg::LAT_W-1:0]   i_cfg_data
);
    lrc_pkg::t_cmd w_cmd;
    lrc_pkg::t_sts w_sts;
    logic [lrc_pkg::PF_W-1:0]  r_pf;
    logic [lrc_pkg::LAT_W-1:0] r_lat;
    logic                      w_hit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf  <= '0;
            r_lat <= lrc_pkg::LAT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lrc_pkg::REG_PREFETCH: r_pf <= i_cfg_data[lrc_pkg::PF_W-1:0];
                lrc_pkg::REG_LATENCY:  r_lat <= i_cfg_data;
                default: r_pf <= r_pf;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    lrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lrc_datapath #(
        .SET_COUNT    (SET_COUNT),
        .WAYS         (WAYS),
        .LINE_BYTES   (LINE_BYTES),
        .ADDR_BITS    (ADDR_BITS),
        .MAX_PREFETCH (MAX_PREFETCH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_func    (i_func),
        .i_address (i_address),
        .i_pf      (r_pf),
        .o_hit     (w_hit)
    );

    assign o_hit         = w_hit;
    assign o_miss_cycles = w_hit ? '0 : r_lat;
endmodule
